// File: hw/rtl/rpn_pkg.sv
package rpn_pkg;

   localparam int CMD_W    = 3;
   localparam int STATUS_W = 3;
   localparam int DATA_W   = 32;
   localparam int DEPTH_W  = 3;

   localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZ    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SAT     = 3'd5;

   localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic load;
      logic push;
      logic pop_x;
      logic pop_y;
      logic exec;
      logic take_unit;
      logic write;
      logic load_out;
   } dp_ctl_type;

   typedef struct packed {
      logic is_push;
      logic uses_unit;
      logic pushes;
      logic unit_done;
      logic unit_busy;
      logic out_free;
   } dp_sts_type;

endpackage

// File: hw/rtl/rpn_muldiv.sv
module rpn_muldiv #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        div_mode,
   input  logic [31:0] opa,
   input  logic [31:0] opb,
   output logic        busy,
   output logic        done,
   output logic [63:0] mag
);

   localparam int DIV_W   = 32 + FRAC_BITS;
   localparam int STEPS_W = $clog2(DIV_W + 1);

   logic               mode_ff;
   logic [31:0]        b_ff;
   logic [63:0]        p_ff;
   logic [31:0]        rem_ff;
   logic [STEPS_W-1:0] step_ff;
   logic               busy_ff;
   logic               done_ff;

   logic [32:0]        add_a;
   logic [32:0]        add_b;
   logic [33:0]        sum;
   logic               ge;
   logic [STEPS_W-1:0] last_step;

   // one shared adder: add for shift-add multiply, subtract for restoring divide
   assign add_a = mode_ff ? {rem_ff, p_ff[DIV_W-1]} : {1'b0, p_ff[63:32]};
   assign add_b = mode_ff ? ~{1'b0, b_ff} : (p_ff[0] ? {1'b0, b_ff} : 33'd0);
   assign sum   = {1'b0, add_a} + {1'b0, add_b} + {33'd0, mode_ff};
   assign ge    = sum[33];
   assign last_step = mode_ff ? STEPS_W'(DIV_W - 1) : STEPS_W'(31);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (step_ff == last_step);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (step_ff == last_step)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mode_ff <= div_mode;
         b_ff    <= opb;
         rem_ff  <= 32'd0;
         step_ff <= '0;
         p_ff    <= div_mode ? (64'(opa) << FRAC_BITS) : {32'd0, opa};
      end else if (busy_ff) begin
         step_ff <= step_ff + STEPS_W'(1);
         if (mode_ff) begin
            rem_ff <= ge ? sum[31:0] : add_a[31:0];
            p_ff   <= 64'({p_ff[DIV_W-2:0], ge});
         end else begin
            p_ff <= {sum[32:0], p_ff[31:1]};
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign mag  = mode_ff ? p_ff : (p_ff >> FRAC_BITS);

endmodule

// File: hw/rtl/rpn_dpath.sv
module rpn_dpath #(
   parameter int STACK_DEPTH = 4,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rpn_pkg::dp_ctl_type           ctl,
   output rpn_pkg::dp_sts_type           sts,
   input  logic [rpn_pkg::CMD_W-1:0]     req_cmd,
   input  logic [rpn_pkg::DATA_W-1:0]    req_value,
   input  logic                          rsp_tready,
   output logic                          rsp_valid,
   output logic [rpn_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rpn_pkg::DATA_W-1:0]    rsp_top,
   output logic [rpn_pkg::DEPTH_W-1:0]   rsp_depth
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] rdata_ff;

   logic [CW-1:0]                 count_ff, count_in;
   logic [rpn_pkg::CMD_W-1:0]     cmd_ff;
   logic [31:0]                   opnd_ff;
   logic [31:0]                   x_ff, y_ff, res_ff;
   logic                          under_ff, sat_ff;
   logic [rpn_pkg::STATUS_W-1:0]  status_ff;

   logic                          rsp_valid_ff;
   logic [rpn_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [31:0]                   rsp_top_ff;
   logic [rpn_pkg::DEPTH_W-1:0]   rsp_depth_ff;

   logic          empty, full, wr_en;
   logic [CW-1:0] cnt_m1;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_data, top_word;
   logic [CW+2:0] cnt_ext;

   logic [31:0] ax, ay;
   logic        neg, x_zero;
   logic [32:0] sum33, dif33;
   logic        unit_busy, unit_done;
   logic [63:0] unit_mag;
   logic        mag_sat;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(STACK_DEPTH));
   assign cnt_m1  = count_ff - CW'(1);
   assign rd_addr = empty ? '0 : cnt_m1[AW-1:0];
   assign wr_addr = count_ff[AW-1:0];
   assign wr_en   = (ctl.push && !full) || ctl.write;
   assign wr_data = ctl.write ? res_ff : opnd_ff;
   assign top_word = empty ? 32'd0 : rdata_ff;
   assign cnt_ext  = {3'd0, count_ff};

   // read port always follows the top of stack; the read data is registered from the address the count gives
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      if (wr_en) begin
         count_in = count_ff + CW'(1);
      end else if ((ctl.pop_x || ctl.pop_y) && !empty) begin
         count_in = cnt_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign ax     = x_ff[31] ? (32'd0 - x_ff) : x_ff;
   assign ay     = y_ff[31] ? (32'd0 - y_ff) : y_ff;
   assign neg    = x_ff[31] ^ y_ff[31];
   assign x_zero = (x_ff == 32'd0);
   assign sum33  = {y_ff[31], y_ff} + {x_ff[31], x_ff};
   assign dif33  = {y_ff[31], y_ff} - {x_ff[31], x_ff};
   assign mag_sat = neg ? (unit_mag > 64'h0000_0000_8000_0000)
                        : (unit_mag > 64'h0000_0000_7FFF_FFFF);

   rpn_muldiv #(
      .FRAC_BITS (FRAC_BITS)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.exec && sts.uses_unit),
      .div_mode (cmd_ff == rpn_pkg::CMD_DIV),
      .opa      (ay),
      .opb      (ax),
      .busy     (unit_busy),
      .done     (unit_done),
      .mag      (unit_mag)
   );

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= req_cmd;
         opnd_ff <= req_value;
      end
      if (ctl.push) begin
         status_ff <= full ? rpn_pkg::ST_FULL : rpn_pkg::ST_OK;
      end
      if (ctl.pop_x) begin
         x_ff     <= top_word;
         under_ff <= empty;
      end
      if (ctl.pop_y) begin
         y_ff     <= top_word;
         under_ff <= under_ff || empty;
      end
      if (ctl.exec) begin
         unique case (cmd_ff)
            rpn_pkg::CMD_ADD: begin
               sat_ff <= sum33[32] ^ sum33[31];
               res_ff <= (sum33[32] ^ sum33[31])
                         ? (sum33[32] ? rpn_pkg::SAT_NEG : rpn_pkg::SAT_POS)
                         : sum33[31:0];
            end
            rpn_pkg::CMD_SUB: begin
               sat_ff <= dif33[32] ^ dif33[31];
               res_ff <= (dif33[32] ^ dif33[31])
                         ? (dif33[32] ? rpn_pkg::SAT_NEG : rpn_pkg::SAT_POS)
                         : dif33[31:0];
            end
            rpn_pkg::CMD_MUL: begin
            end
            rpn_pkg::CMD_DIV: begin
               if (x_zero) begin
                  status_ff <= rpn_pkg::ST_DIVZ;
               end
            end
            default: begin
               status_ff <= rpn_pkg::ST_INVALID;
            end
         endcase
      end
      if (ctl.take_unit) begin
         sat_ff <= mag_sat;
         if (mag_sat) begin
            res_ff <= neg ? rpn_pkg::SAT_NEG : rpn_pkg::SAT_POS;
         end else begin
            res_ff <= neg ? (32'd0 - unit_mag[31:0]) : unit_mag[31:0];
         end
      end
      if (ctl.write) begin
         status_ff <= under_ff ? rpn_pkg::ST_UNDER
                    : (sat_ff ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_status_ff <= status_ff;
         rsp_top_ff    <= top_word;
         rsp_depth_ff  <= cnt_ext[2:0];
      end
   end

   assign sts.is_push   = (cmd_ff == rpn_pkg::CMD_PUSH);
   assign sts.uses_unit = (cmd_ff == rpn_pkg::CMD_MUL)
                       || ((cmd_ff == rpn_pkg::CMD_DIV) && !x_zero);
   assign sts.pushes    = (cmd_ff == rpn_pkg::CMD_ADD) || (cmd_ff == rpn_pkg::CMD_SUB)
                       || sts.uses_unit;
   assign sts.unit_done = unit_done;
   assign sts.unit_busy = unit_busy;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_top    = rsp_top_ff;
   assign rsp_depth  = rsp_depth_ff;

endmodule

// File: hw/rtl/rpn_ctrl.sv
module rpn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rpn_pkg::dp_sts_type sts,
   output rpn_pkg::dp_ctl_type ctl
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_POPX     = 4'd2;
   localparam logic [3:0] S_GAP      = 4'd3;
   localparam logic [3:0] S_POPY     = 4'd4;
   localparam logic [3:0] S_EXEC     = 4'd5;
   localparam logic [3:0] S_UNIT     = 4'd6;
   localparam logic [3:0] S_WRITE    = 4'd7;
   localparam logic [3:0] S_SETTLE   = 4'd8;
   localparam logic [3:0] S_LOAD     = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (sts.is_push) begin
               ctl.push = 1'b1;
               state_in = S_SETTLE;
            end else begin
               state_in = S_POPX;
            end
         end
         S_POPX: begin
            ctl.pop_x = 1'b1;
            state_in  = S_GAP;
         end
         S_GAP: begin
            state_in = S_POPY;
         end
         S_POPY: begin
            ctl.pop_y = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            priority if (sts.uses_unit) begin
               state_in = S_UNIT;
            end else if (sts.pushes) begin
               state_in = S_WRITE;
            end else begin
               state_in = S_SETTLE;
            end
         end
         S_UNIT: begin
            if (sts.unit_done) begin
               ctl.take_unit = 1'b1;
               state_in      = S_WRITE;
            end
         end
         S_WRITE: begin
            ctl.write = 1'b1;
            state_in  = S_SETTLE;
         end
         S_SETTLE: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (sts.out_free) begin
               ctl.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/rpn_stack_calculator.sv
// channel | dir | tdata (low bit up)                       | tuser
// req     | in  | operand_value[31:0]                      | command[2:0]
// rsp     | out | top_value[31:0], stack_depth[34:32], pad | status[2:0]
//
// One item at a time: the next beat is accepted only after the previous result is loaded.
// Multiply and divide run on the shared shift-add / restoring-divide unit; push, add, subtract
// and the invalid and divide-by-zero cases do not use it.
// Synchronous active-high reset empties the stack; entries are not cleared.
// A stalled result holds the block in its final state; the next beat is taken once it loads.
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = 4,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // operand_value[31:0]
   input  logic [2:0]  req_tuser,   // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // top_value[31:0], stack_depth[34:32], zero[39:35]
   output logic [2:0]  rsp_tuser    // status[2:0]
);

   rpn_pkg::dp_ctl_type ctl;
   rpn_pkg::dp_sts_type sts;

   logic [rpn_pkg::DATA_W-1:0]  rsp_top;
   logic [rpn_pkg::DEPTH_W-1:0] rsp_depth;

   rpn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   rpn_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_cmd    (req_tuser),
      .req_value  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_top    (rsp_top),
      .rsp_depth  (rsp_depth)
   );

   assign rsp_tdata = {5'd0, rsp_depth, rsp_top};

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending beat");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      sts.unit_busy |-> !req_tready)
      else $error("input accepted while arithmetic unit busy");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat accepted before first finished");

endmodule

// File: sim/tb.sv
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STK_LEVELS   = 4;
   localparam int Q_FRAC       = 16;
   localparam int RANDOM_ITEMS = 700;
   localparam int STALL_LIMIT  = 2000;
   localparam int PRESSURE_AT  = 300;
   localparam int PRESSURE_LEN = 300;
   localparam int DRAIN_CYCLES = 80;

   localparam logic [rpn_pkg::CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
   localparam logic [rpn_pkg::CMD_W-1:0] CMD_BAD_LAST  = 3'd7;

   localparam logic [rpn_pkg::DATA_W-1:0] Q_ONE     = 32'h0001_0000;
   localparam logic [rpn_pkg::DATA_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;

   typedef struct {
      logic [rpn_pkg::CMD_W-1:0]  command;
      logic [rpn_pkg::DATA_W-1:0] operand;
   } rpn_cmd_type;

   typedef struct {
      logic [rpn_pkg::STATUS_W-1:0] status;
      logic [rpn_pkg::DATA_W-1:0]   top;
      logic [rpn_pkg::DEPTH_W-1:0]  depth;
   } rpn_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   logic req_beat = 1'b0;
   logic rsp_beat = 1'b0;

   rpn_cmd_type    pending_cmds[$];
   rpn_result_type awaited_results[$];

   logic [rpn_pkg::DATA_W-1:0] model_stack[STK_LEVELS];
   int                         model_depth = 0;

   int errors       = 0;
   int cmds_taken   = 0;
   int quiet_cycles = 0;
   int calm         = 0;
   int req_gap      = 0;
   int rsp_idle     = 0;
   bit pressure_done = 0;

   rpn_stack_calculator #(
      .STACK_DEPTH(STK_LEVELS),
      .FRAC_BITS  (Q_FRAC)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm > 0 || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [rpn_pkg::DATA_W-1:0] pick_operand();
      logic [31:0] s;
      int r;
      s = $urandom;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 5))
            0: return '0;
            1: return rpn_pkg::SAT_POS;
            2: return rpn_pkg::SAT_NEG;
            3: return 32'h0000_0001;
            4: return Q_NEG_ONE;
            default: return Q_ONE;
         endcase
      end
      if (r < 6) return {{12{s[19]}}, s[19:0]};
      return s;
   endfunction

   function automatic logic [rpn_pkg::DATA_W-1:0] take_operand(inout logic under);
      if (model_depth == 0) begin
         under = 1'b1;
         return '0;
      end
      model_depth--;
      return model_stack[model_depth];
   endfunction

   // one command against the local copy of the stack
   function automatic rpn_result_type rpn_eval(rpn_cmd_type c);
      rpn_result_type r;
      logic        under, sat, pushes;
      longint      x, y, ax, ay, v;
      logic [rpn_pkg::DATA_W-1:0] res;
      r.status = rpn_pkg::ST_OK;
      under  = 1'b0;
      sat    = 1'b0;
      pushes = 1'b1;
      res    = '0;
      if (c.command == rpn_pkg::CMD_PUSH) begin
         if (model_depth >= STK_LEVELS) begin
            r.status = rpn_pkg::ST_FULL;
         end else begin
            model_stack[model_depth] = c.operand;
            model_depth++;
         end
      end else begin
         x  = longint'($signed(take_operand(under)));
         y  = longint'($signed(take_operand(under)));
         ax = (x < 0) ? -x : x;
         ay = (y < 0) ? -y : y;
         v  = 0;
         case (c.command)
            rpn_pkg::CMD_ADD: v = y + x;
            rpn_pkg::CMD_SUB: v = y - x;
            rpn_pkg::CMD_MUL: begin
               v = (ay * ax) >>> Q_FRAC;
               if ((x < 0) != (y < 0)) v = -v;
            end
            rpn_pkg::CMD_DIV: begin
               if (ax == 0) begin
                  r.status = rpn_pkg::ST_DIVZ;
                  pushes   = 1'b0;
               end else begin
                  v = (ay <<< Q_FRAC) / ax;
                  if ((x < 0) != (y < 0)) v = -v;
               end
            end
            default: begin
               r.status = rpn_pkg::ST_INVALID;
               pushes   = 1'b0;
            end
         endcase
         if (pushes) begin
            if (v > longint'(32'sh7FFF_FFFF)) begin
               sat = 1'b1;
               res = rpn_pkg::SAT_POS;
            end else if (v < -longint'(64'sh8000_0000)) begin
               sat = 1'b1;
               res = rpn_pkg::SAT_NEG;
            end else begin
               res = v[31:0];
            end
            model_stack[model_depth] = res;
            model_depth++;
            if (under) r.status = rpn_pkg::ST_UNDER;
            else if (sat) r.status = rpn_pkg::ST_SAT;
         end
      end
      r.top   = (model_depth == 0) ? '0 : model_stack[model_depth - 1];
      r.depth = model_depth[rpn_pkg::DEPTH_W-1:0];
      return r;
   endfunction

   task automatic add_cmd(logic [rpn_pkg::CMD_W-1:0] c, logic [rpn_pkg::DATA_W-1:0] v);
      rpn_cmd_type it;
      it.command = c;
      it.operand = v;
      pending_cmds.push_back(it);
   endtask

   // sender
   always @(negedge clock) begin
      rpn_cmd_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            it = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= it.operand;
            req_tuser  <= it.command;
            req_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off once the run is well under way
   always @(negedge clock) begin
      if (rsp_beat) rsp_idle = pick_gap();
      if (!pressure_done && cmds_taken >= PRESSURE_AT) begin
         rsp_idle = PRESSURE_LEN;
         pressure_done = 1;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_idle > 0) begin
         rsp_idle = rsp_idle - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      rpn_cmd_type    it;
      rpn_result_type want;
      req_beat <= req_tvalid && req_tready;
      rsp_beat <= rsp_tvalid && rsp_tready;
      if (req_tvalid && req_tready) begin
         it.command = req_tuser;
         it.operand = req_tdata;
         awaited_results.push_back(rpn_eval(it));
         cmds_taken++;
      end
      if (rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $error("result beat with nothing outstanding");
            errors++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[31:0] !== want.top) begin
               $error("top_value expected %h actual %h", want.top, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[34:32] !== want.depth) begin
               $error("stack_depth expected %0d actual %0d", want.depth, rsp_tdata[34:32]);
               errors++;
            end
         end
      end
   end

   // watchdog; also opens occasional stretches without idling
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (calm > 0) calm--;
      else if ($urandom_range(0, 499) == 0) calm = $urandom_range(50, 200);
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int r;
      // empty stack: underflow, invalid and divide by zero with nothing to pop
      add_cmd(rpn_pkg::CMD_ADD, '0);
      add_cmd(CMD_BAD_FIRST, '0);
      add_cmd(rpn_pkg::CMD_DIV, '0);
      // saturating add and subtract
      add_cmd(rpn_pkg::CMD_PUSH, rpn_pkg::SAT_POS);
      add_cmd(rpn_pkg::CMD_PUSH, rpn_pkg::SAT_POS);
      add_cmd(rpn_pkg::CMD_ADD, '0);
      add_cmd(rpn_pkg::CMD_PUSH, rpn_pkg::SAT_NEG);
      add_cmd(rpn_pkg::CMD_SUB, '0);
      add_cmd(rpn_pkg::CMD_PUSH, rpn_pkg::SAT_NEG);
      add_cmd(rpn_pkg::CMD_PUSH, Q_ONE);
      add_cmd(rpn_pkg::CMD_SUB, '0);
      // saturating multiply, both signs
      add_cmd(rpn_pkg::CMD_MUL, '0);
      add_cmd(rpn_pkg::CMD_PUSH, Q_NEG_ONE);
      add_cmd(rpn_pkg::CMD_MUL, '0);
      // fill, then push onto a full stack
      add_cmd(rpn_pkg::CMD_PUSH, 32'h0002_0000);
      add_cmd(rpn_pkg::CMD_PUSH, 32'h0003_0000);
      add_cmd(rpn_pkg::CMD_PUSH, 32'hFFFE_0000);
      add_cmd(rpn_pkg::CMD_PUSH, 32'h0005_0000);
      add_cmd(rpn_pkg::CMD_DIV, '0);
      add_cmd(rpn_pkg::CMD_PUSH, '0);
      add_cmd(rpn_pkg::CMD_DIV, '0);
      add_cmd(rpn_pkg::CMD_PUSH, 32'h0000_0001);
      add_cmd(rpn_pkg::CMD_DIV, '0);
      add_cmd(CMD_BAD_FIRST + 3'd1, 32'hFFFF_FFFF);
      add_cmd(CMD_BAD_LAST, '0);
      add_cmd(rpn_pkg::CMD_MUL, '0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 46) add_cmd(rpn_pkg::CMD_PUSH, pick_operand());
         else if (r < 58) add_cmd(rpn_pkg::CMD_ADD, pick_operand());
         else if (r < 70) add_cmd(rpn_pkg::CMD_SUB, pick_operand());
         else if (r < 82) add_cmd(rpn_pkg::CMD_MUL, pick_operand());
         else if (r < 94) add_cmd(rpn_pkg::CMD_DIV, pick_operand());
         else add_cmd(CMD_BAD_FIRST + 3'($urandom_range(0, 2)), pick_operand());
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() > 0 || req_tvalid || awaited_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && awaited_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
